### rtl/timer_queue_scheduler_top_macros.svh
// Assertion macros shared by the checker files of the timer queue scheduler.
// Holds nothing but macro definitions.
`ifndef TIMER_QUEUE_SCHEDULER_TOP_MACROS_SVH
`define TIMER_QUEUE_SCHEDULER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TQS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define TQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/tqs_pkg.sv
// Package of the timer queue scheduler: sizes, item kinds and cell types.
// Depends on nothing.
`default_nettype none
package tqs_pkg;
  localparam int NumTimers = 16;
  localparam int IdW       = 4;
  localparam int TimeW     = 48;
  localparam int OrdW      = 32;

  // Cycles for a state change to ripple through the registered cell row.
  localparam int SettleCyc = NumTimers;
  localparam int CntW      = $clog2(SettleCyc + 1);

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  localparam logic [TimeW-1:0] TIME_MAX = {TimeW{1'b1}};
  localparam logic [15:0] NT_NONE = 16'hFFFF;
  localparam logic [15:0] NT_MAX  = 16'h7FFF;

  // Candidate word passed along the comparison chain.
  typedef struct packed {
    logic             vld;
    logic [TimeW-1:0] due;
    logic [OrdW-1:0]  ord;
    logic [IdW-1:0]   id;
  } cand_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic             arm;      // load a fresh arming
    logic             disarm;   // stop
    logic [IdW-1:0]   id;
    logic [15:0]      reload;
    logic [7:0]       rep;
    logic             fire;     // fire the selected cell
    logic             clr_done; // new tick begins
    logic [TimeW-1:0] due;      // due time for arm or re-arm
    logic [OrdW-1:0]  ord;
  } cmd_t;
endpackage
`default_nettype wire

### rtl/tqs_cell.sv
// One timer cell: stores one timer and compares itself against the candidate
// word arriving from its left neighbor. Depends on tqs_pkg.
`default_nettype none
module tqs_cell
  import tqs_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [IdW-1:0]  my_id,
  input  wire cmd_t            cmd,
  input  wire logic            skip_done,
  input  wire cand_t           cand_in,
  output cand_t                cand_out,
  output logic [15:0]          reload_o,
  output logic [7:0]           rep_o
);
  logic             armed_r, armed_nxt;
  logic             done_r, done_nxt;
  logic [TimeW-1:0] due_r, due_nxt;
  logic [OrdW-1:0]  ord_r, ord_nxt;
  logic [15:0]      reload_r, reload_nxt;
  logic [7:0]       rep_r, rep_nxt;
  cand_t            cand_r, cand_nxt;
  logic             sel, fire_me, better;

  assign sel = (cmd.id == my_id);
  assign fire_me = cmd.fire && sel;
  assign reload_o = reload_r;
  assign rep_o = rep_r;
  assign cand_out = cand_r;

  // Compare this timer with the incoming candidate; the winner is registered.
  always_comb begin
    better = armed_r && !(skip_done && done_r) &&
             (!cand_in.vld || due_r < cand_in.due ||
              (due_r == cand_in.due && ord_r < cand_in.ord));
    cand_nxt = cand_in;
    if (better) begin
      cand_nxt = '{vld: 1'b1, due: due_r, ord: ord_r, id: my_id};
    end
  end

  // Update on commands.
  always_comb begin
    armed_nxt = armed_r; done_nxt = done_r; due_nxt = due_r; ord_nxt = ord_r;
    reload_nxt = reload_r; rep_nxt = rep_r;
    if (cmd.clr_done) done_nxt = 1'b0;
    if (cmd.arm && sel) begin
      armed_nxt = 1'b1; due_nxt = cmd.due; ord_nxt = cmd.ord;
      reload_nxt = cmd.reload; rep_nxt = cmd.rep;
    end
    if (cmd.disarm && sel) armed_nxt = 1'b0;
    if (fire_me) begin
      done_nxt = 1'b1;
      rep_nxt = (rep_r != 8'd0) ? rep_r - 8'd1 : 8'd0;
      if (rep_r > 8'd1) begin
        armed_nxt = 1'b1; due_nxt = cmd.due; ord_nxt = cmd.ord;
      end else begin
        armed_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      done_r  <= 1'b0;
      cand_r  <= '0;
    end else begin
      armed_r <= armed_nxt;
      done_r  <= done_nxt;
      cand_r  <= cand_nxt;
    end
    due_r    <= due_nxt;
    ord_r    <= ord_nxt;
    reload_r <= reload_nxt;
    rep_r    <= rep_nxt;
  end
endmodule
`default_nettype wire

### rtl/tqs_ctrl.sv
// Sequencer of the timer queue scheduler: takes commands, walks the cell
// chain result and issues results. Depends on tqs_pkg.
`default_nettype none
module tqs_ctrl
  import tqs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_kind,
  input  wire logic [3:0]       in_timer_id,
  input  wire logic [15:0]      in_timeout_ms,
  input  wire logic [7:0]       in_repeat_count,
  input  wire logic [47:0]      in_now_ms,
  input  wire cand_t            best,
  input  wire logic [15:0]      best_reload,
  input  wire logic [7:0]       best_rep,
  output cmd_t                  cmd,
  output logic                  skip_done,
  output logic                  out_strobe,
  output logic                  out_fired,
  output logic [3:0]            out_fired_timer,
  output logic signed [15:0]    out_next_timeout,
  output logic                  out_last
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       st_r, st_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [TimeW-1:0] now_r, now_nxt;
  logic [OrdW-1:0]  ocnt_r, ocnt_nxt;
  logic [TimeW:0]   sum;
  logic [TimeW-1:0] due_calc, diff;
  logic [15:0]      reload_sel, tmo_fix;
  logic             strb_r, strb_nxt, fired_r, fired_nxt, last_r, last_nxt;
  logic [3:0]       fid_r, fid_nxt;
  logic [15:0]      nt_r, nt_nxt;
  logic             id_ok, settled, rearm;

  assign busy = (st_r != ST_IDLE);
  assign id_ok = ({1'b0, in_timer_id} < 5'(NumTimers));
  assign tmo_fix = (in_timeout_ms == 16'd0) ? 16'd1 : in_timeout_ms;
  assign reload_sel = (st_r == ST_IDLE) ? tmo_fix : best_reload;
  // Saturating due time from the current time.
  assign sum = {1'b0, now_r} + {{(TimeW-16+1){1'b0}}, reload_sel};
  assign due_calc = sum[TimeW] ? TIME_MAX : sum[TimeW-1:0];
  assign diff = best.due - now_r;
  assign skip_done = (st_r == ST_SCAN);
  // The chain end is valid once every cell has seen the current state.
  assign settled = (cnt_r == CntW'(SettleCyc));
  // The fired cell re-arms while its decremented repeat count stays nonzero.
  assign rearm = (best_rep > 8'd1);

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; now_nxt = now_r; ocnt_nxt = ocnt_r;
    strb_nxt = 1'b0; fired_nxt = 1'b0; fid_nxt = '0; nt_nxt = '0; last_nxt = 1'b0;
    cmd = '0;
    cmd.id = in_timer_id;
    cmd.reload = tmo_fix;
    cmd.rep = in_repeat_count;
    cmd.due = due_calc;
    cmd.ord = ocnt_r;
    case (st_r)
      ST_IDLE: begin
        if (start) begin
          cnt_nxt = '0;
          case (in_kind)
            KIND_TICK: begin
              now_nxt = in_now_ms;
              cmd.clr_done = 1'b1;
              st_nxt = ST_SCAN;
            end
            KIND_START: begin
              if (id_ok) begin
                cmd.arm = 1'b1;
                ocnt_nxt = ocnt_r + 1'b1;
              end
              st_nxt = ST_FIN;
            end
            KIND_STOP: begin
              cmd.disarm = id_ok;
              st_nxt = ST_FIN;
            end
            default: st_nxt = ST_FIN;
          endcase
        end
      end
      ST_SCAN: begin
        // Fire the earliest due timer not yet fired this tick.
        if (!settled) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (best.vld && best.due <= now_r) begin
          cmd.fire = 1'b1;
          cmd.id = best.id;
          strb_nxt = 1'b1; fired_nxt = 1'b1; fid_nxt = best.id;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = '0;
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!settled) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          strb_nxt = 1'b1; last_nxt = 1'b1;
          if (!best.vld) nt_nxt = NT_NONE;
          else if (best.due <= now_r) nt_nxt = '0;
          else if (diff > {{(TimeW-16){1'b0}}, NT_MAX}) nt_nxt = NT_MAX;
          else nt_nxt = diff[15:0];
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // The order counter also advances on every re-arm of a fired timer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; now_r <= '0; ocnt_r <= '0; strb_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; now_r <= now_nxt; strb_r <= strb_nxt;
      ocnt_r <= ocnt_nxt + {{(OrdW-1){1'b0}}, cmd.fire && rearm};
    end
    fired_r <= fired_nxt; fid_r <= fid_nxt; nt_r <= nt_nxt; last_r <= last_nxt;
  end

  assign out_strobe = strb_r;
  assign out_fired = fired_r;
  assign out_fired_timer = fid_r;
  assign out_next_timeout = nt_r;
  assign out_last = last_r;
endmodule
`default_nettype wire

### rtl/timer_queue_scheduler_top.sv
// Top level of the timer queue scheduler: controller plus a chain of timer
// cells. Depends on tqs_pkg, tqs_cell and tqs_ctrl.
//
// Usage: drive the in_ fields and raise start while busy is low; the word is
// taken at that edge. Each cell registers the candidate word it hands on, so
// after any change of timer state the controller waits for the earliest timer
// to reach the end of the row before it acts on it. A start or stop word gives
// its one result once the row has settled. A tick word with k expiries gives k
// fired results, each once the row has settled again, then a closing result
// with out_last high.
// Results appear for one cycle under out_strobe and must be taken then: the
// receiver cannot stall. A new word can be taken at the edge that ends the
// closing result, so a word is not taken before the last one is through.
// After reset all timers are idle, time and the order counter are zero.
// busy is high from the accepting edge until the closing result is shown.
`default_nettype none
module timer_queue_scheduler_top
  import tqs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_kind,
  input  wire logic [3:0]         in_timer_id,
  input  wire logic [15:0]        in_timeout_ms,
  input  wire logic [7:0]         in_repeat_count,
  input  wire logic [47:0]        in_now_ms,
  output logic                    out_strobe,
  output logic                    out_fired,
  output logic [3:0]              out_fired_timer,
  output logic signed [15:0]      out_next_timeout,
  output logic                    out_last
);
  cmd_t        cmd;
  logic        skip_done;
  cand_t       chain [NumTimers+1];
  logic [15:0] reload_a [NumTimers];
  logic [7:0]  rep_a [NumTimers];
  logic [15:0] best_reload;
  logic [7:0]  best_rep;

  assign chain[0] = '0;

  // Row of timer cells; the candidate word moves left to right.
  for (genvar i = 0; i < NumTimers; i++) begin : g_cell
    tqs_cell u_cell (
      .clk, .rst_n, .my_id(IdW'(i)), .cmd, .skip_done,
      .cand_in(chain[i]), .cand_out(chain[i+1]),
      .reload_o(reload_a[i]), .rep_o(rep_a[i])
    );
  end

  assign best_reload = reload_a[chain[NumTimers].id];
  assign best_rep = rep_a[chain[NumTimers].id];

  tqs_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .in_kind, .in_timer_id, .in_timeout_ms,
    .in_repeat_count, .in_now_ms, .best(chain[NumTimers]), .best_reload,
    .best_rep, .cmd, .skip_done, .out_strobe, .out_fired, .out_fired_timer,
    .out_next_timeout, .out_last
  );
endmodule
`default_nettype wire

### rtl/tqs_checker.sv
// Port checker for the timer queue scheduler, bound to the top level.
// Depends on timer_queue_scheduler_top_macros.svh.
`default_nettype none
`include "timer_queue_scheduler_top_macros.svh"
module tqs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_strobe,
  input wire logic        out_fired,
  input wire logic        out_last
);
  `TQS_ASSERT_NEXT(a_acc_busy, start && !busy, busy, "busy not raised after accept")
  `TQS_ASSERT_IMP(a_last_idle, out_strobe && out_last, !busy, "busy high at closing word")
  `TQS_ASSERT_IMP(a_fire_not_last, out_strobe && out_fired, !out_last, "fired word marked last")
  `TQS_ASSERT_IMP(a_strobe_busy, out_strobe && !out_last, busy, "fired word while idle")
endmodule

bind timer_queue_scheduler_top tqs_checker u_tqs_checker (
  .clk, .rst_n, .start, .busy, .out_strobe, .out_fired, .out_last
);
`default_nettype wire

### bench/tb.sv
// Self-checking bench for the timer queue scheduler: a directed table, then random words.
// Depends on tqs_pkg and timer_queue_scheduler_top.
module tb;
  import tqs_pkg::*;

  typedef struct packed {
    logic        fired;
    logic [3:0]  fired_timer;
    logic [15:0] next_timeout;
    logic        last;
  } sched_res_t;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  id;
    logic [15:0] tmo;
    logic [7:0]  rep;
    logic [47:0] now;
    logic        chk;   // typed-in closing result below applies
    logic [15:0] nt;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = '0;
  logic [3:0] in_timer_id = '0;
  logic [15:0] in_timeout_ms = '0;
  logic [7:0] in_repeat_count = '0;
  logic [47:0] in_now_ms = '0;
  logic out_strobe, out_fired, out_last;
  logic [3:0] out_fired_timer;
  logic signed [15:0] out_next_timeout;

  timer_queue_scheduler_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_timer_id(in_timer_id), .in_timeout_ms(in_timeout_ms),
    .in_repeat_count(in_repeat_count), .in_now_ms(in_now_ms),
    .out_strobe(out_strobe), .out_fired(out_fired), .out_fired_timer(out_fired_timer),
    .out_next_timeout(out_next_timeout), .out_last(out_last)
  );

  always #1 clk = ~clk;

  // Predictor state.
  logic        t_armed [NumTimers];
  logic [47:0] t_due   [NumTimers];
  logic [7:0]  t_reps  [NumTimers];
  logic [31:0] t_ord   [NumTimers];
  logic [15:0] t_reload[NumTimers];
  logic [31:0] ord_ctr;
  logic [47:0] cur_time;

  sched_res_t expected_results[$];
  int errors = 0;

  function automatic logic [47:0] sat_add(logic [47:0] a, logic [15:0] d);
    logic [48:0] s;
    s = {1'b0, a} + d;
    return s[48] ? TIME_MAX : s[47:0];
  endfunction

  function automatic int earliest_timer(logic skip[NumTimers]);
    int best;
    best = -1;
    for (int t = 0; t < NumTimers; t++) begin
      if (!t_armed[t] || skip[t]) continue;
      if (best < 0 || t_due[t] < t_due[best] ||
          (t_due[t] == t_due[best] && t_ord[t] < t_ord[best]))
        best = t;
    end
    return best;
  endfunction

  task automatic arm_one(int t);
    t_due[t] = sat_add(cur_time, t_reload[t]);
    t_ord[t] = ord_ctr;
    ord_ctr = ord_ctr + 1;
    t_armed[t] = 1'b1;
  endtask

  // Push the results that one word produces; return the closing next_timeout.
  task automatic predict_schedule(input logic [1:0] kind, input logic [3:0] id,
                                  input logic [15:0] tmo, input logic [7:0] rep,
                                  input logic [47:0] now, output logic [15:0] nt);
    logic done[NumTimers];
    logic none[NumTimers];
    sched_res_t r;
    int b;
    logic [47:0] diff;
    for (int t = 0; t < NumTimers; t++) begin
      done[t] = 1'b0;
      none[t] = 1'b0;
    end
    if (kind == KIND_TICK) begin
      cur_time = now;
      forever begin
        b = earliest_timer(done);
        if (b < 0 || t_due[b] > cur_time) break;
        done[b] = 1'b1;
        t_armed[b] = 1'b0;
        if (t_reps[b] != 0) begin
          t_reps[b] = t_reps[b] - 1;
          if (t_reps[b] != 0) arm_one(b);
        end
        r = '{fired: 1'b1, fired_timer: b[3:0], next_timeout: 16'd0, last: 1'b0};
        expected_results.push_back(r);
      end
    end else if (kind == KIND_START) begin
      t_reload[id] = (tmo == 0) ? 16'd1 : tmo;
      t_reps[id] = rep;
      arm_one(id);
    end else if (kind == KIND_STOP) begin
      t_armed[id] = 1'b0;
    end
    b = earliest_timer(none);
    if (b < 0) nt = NT_NONE;
    else if (t_due[b] <= cur_time) nt = 16'd0;
    else begin
      diff = t_due[b] - cur_time;
      nt = (diff > 48'h7FFF) ? NT_MAX : diff[15:0];
    end
    r = '{fired: 1'b0, fired_timer: 4'd0, next_timeout: nt, last: 1'b1};
    expected_results.push_back(r);
  endtask

  // Result checker.
  always @(posedge clk) begin
    sched_res_t got, exp_r;
    if (rst_n && out_strobe) begin
      got = '{out_fired, out_fired_timer, out_next_timeout, out_last};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.fired !== exp_r.fired) begin
          $display("%0t: fired exp %0d got %0d", $time, exp_r.fired, got.fired); errors++;
        end
        if (got.fired_timer !== exp_r.fired_timer) begin
          $display("%0t: fired_timer exp %0d got %0d", $time, exp_r.fired_timer,
                   got.fired_timer); errors++;
        end
        if (got.next_timeout !== exp_r.next_timeout) begin
          $display("%0t: next_timeout exp %h got %h", $time, exp_r.next_timeout,
                   got.next_timeout); errors++;
        end
        if (got.last !== exp_r.last) begin
          $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last); errors++;
        end
      end
    end
  end

  logic [47:0] sim_now = '0;

  // Send one word, wait for acceptance, then an optional gap.
  task automatic send_word(input logic [1:0] kind, input logic [3:0] id,
                           input logic [15:0] tmo, input logic [7:0] rep,
                           input logic [47:0] now, input logic chk,
                           input logic [15:0] want_nt);
    logic [15:0] nt;
    int gap;
    in_kind <= kind; in_timer_id <= id; in_timeout_ms <= tmo;
    in_repeat_count <= rep; in_now_ms <= now; start <= 1'b1;
    // busy is sampled mid-cycle, where it is stable up to the next edge.
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_schedule(kind, id, tmo, rep, now, nt);
    if (chk && nt !== want_nt) begin
      $display("%0t: table next_timeout exp %h predicted %h", $time, want_nt, nt);
      errors++;
    end
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
          (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3));
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  dir_row_t dir_table[] = '{
    '{KIND_TICK,  4'd0,  16'd0,     8'd0,   48'd0,       1'b1, NT_NONE},
    '{KIND_STOP,  4'd3,  16'd0,     8'd0,   48'd0,       1'b1, NT_NONE},
    '{KIND_START, 4'd0,  16'd0,     8'd1,   48'd0,       1'b1, 16'd1},
    '{KIND_TICK,  4'd0,  16'd0,     8'd0,   48'd1,       1'b1, NT_NONE},
    '{KIND_START, 4'd15, 16'hFFFF,  8'hFF,  48'd0,       1'b1, NT_MAX},
    '{KIND_START, 4'd1,  16'd5,     8'd3,   48'd0,       1'b0, 16'd0},
    '{KIND_START, 4'd2,  16'd5,     8'd0,   48'd0,       1'b0, 16'd0},
    '{KIND_START, 4'd1,  16'd5,     8'd3,   48'd0,       1'b0, 16'd0},
    '{KIND_TICK,  4'd0,  16'd0,     8'd0,   48'd6,       1'b0, 16'd0},
    '{KIND_TICK,  4'd0,  16'd0,     8'd0,   48'd20,      1'b0, 16'd0},
    '{KIND_STOP,  4'd15, 16'd0,     8'd0,   48'd0,       1'b0, 16'd0},
    '{2'd3,       4'd7,  16'h1234,  8'd9,   48'd5,       1'b0, 16'd0},
    '{KIND_TICK,  4'd0,  16'd0,     8'd0,   TIME_MAX-2,  1'b0, 16'd0},
    '{KIND_START, 4'd4,  16'd100,   8'd200, 48'd0,       1'b0, 16'd0},
    '{KIND_START, 4'd5,  16'd3,     8'd2,   48'd0,       1'b0, 16'd0},
    '{KIND_TICK,  4'd0,  16'd0,     8'd0,   TIME_MAX,    1'b0, 16'd0},
    '{KIND_TICK,  4'd0,  16'd0,     8'd0,   TIME_MAX,    1'b0, 16'd0},
    '{KIND_TICK,  4'd0,  16'd0,     8'd0,   48'd10,      1'b0, 16'd0},
    '{KIND_STOP,  4'd4,  16'd0,     8'd0,   48'd0,       1'b0, 16'd0},
    '{KIND_STOP,  4'd5,  16'd0,     8'd0,   48'd0,       1'b0, 16'd0},
    '{KIND_STOP,  4'd15, 16'd0,     8'd0,   48'd0,       1'b0, 16'd0},
    '{KIND_TICK,  4'd0,  16'd0,     8'd0,   48'd11,      1'b1, NT_NONE}
  };

  initial begin
    int r;
    logic [1:0] k;
    logic [15:0] tmo;
    for (int t = 0; t < NumTimers; t++) t_armed[t] = 1'b0;
    ord_ctr = '0;
    cur_time = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i])
      send_word(dir_table[i].kind, dir_table[i].id, dir_table[i].tmo, dir_table[i].rep,
                dir_table[i].now, dir_table[i].chk, dir_table[i].nt);

    // Hold off until the block has drained.
    start <= 1'b0;
    wait (expected_results.size() == 0);
    @(posedge clk);

    // Random part: mostly starts and advancing ticks, some stops and noise.
    sim_now = 48'd100;
    for (int n = 0; n < 260; n++) begin
      r = $urandom_range(0, 99);
      tmo = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      if (r < 40) begin
        send_word(KIND_START, 4'($urandom), tmo,
                  ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)),
                  48'($urandom), 1'b0, 16'd0);
      end else if (r < 75) begin
        if ($urandom_range(0, 19) == 0)
          sim_now = {16'($urandom), 32'($urandom)};
        else
          sim_now = sim_now + $urandom_range(0, 30);
        send_word(KIND_TICK, 4'($urandom), 16'($urandom), 8'($urandom), sim_now,
                  1'b0, 16'd0);
      end else if (r < 92) begin
        send_word(KIND_STOP, 4'($urandom), 16'($urandom), 8'($urandom), 48'($urandom),
                  1'b0, 16'd0);
      end else begin
        k = 2'd3;
        send_word(k, 4'($urandom), tmo, 8'($urandom), {16'($urandom), 32'($urandom)},
                  1'b0, 16'd0);
      end
    end
    start <= 1'b0;

    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog.
  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
